FILE: sv/hkrt_pkg.sv
// Shared types and constants for the hall-effect key rapid trigger unit.
package hkrt_pkg;

    // Sizing
    localparam int NUM_KEYS     = 8;
    localparam int SAMPLE_BITS  = 12;
    localparam int KEY_BITS     = 3;
    localparam int KEY_IDX_BITS = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int DIST_BITS    = 10;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 10;

    // Divider sizing: quotient bits cover any total travel, numerator is |s - rest| * travel
    localparam int QUO_BITS     = DIST_BITS + 1;
    localparam int NUM_BITS     = SAMPLE_BITS + DIST_BITS;
    localparam int DIV_CNT_BITS = $clog2(QUO_BITS + 1);
    localparam int LVL_EXT_BITS = ((SAMPLE_BITS > DIST_BITS) ? SAMPLE_BITS : DIST_BITS) + 1;
    localparam int SGN_BITS     = DIST_BITS + 2;

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_INVERT      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRAVEL      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEAD_ZONE   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE        = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTUATION   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESS_THR   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_THR = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONT_RESET  = 3'd7;

    // Trigger modes
    localparam logic [1:0] MODE_STATIC     = 2'd0;
    localparam logic [1:0] MODE_RAPID      = 2'd1;
    localparam logic [1:0] MODE_CONTINUOUS = 2'd2;
    localparam logic [1:0] MODE_RAPID_FREE = 2'd3;

    typedef struct packed {
        logic [KEY_BITS-1:0]    key_index;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   filter_ready;
    } t_in_item;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key_out;
        logic                 pressed;
        logic                 is_calibrated;
        logic [DIST_BITS-1:0] distance;
    } t_out_item;

    typedef struct packed {
        logic                 invert_orientation;
        logic [DIST_BITS-1:0] total_travel;
        logic [DIST_BITS-1:0] dead_zone;
        logic [1:0]           trigger_mode;
        logic [DIST_BITS-1:0] actuation_point;
        logic [DIST_BITS-1:0] press_threshold;
        logic [DIST_BITS-1:0] release_threshold;
        logic [DIST_BITS-1:0] continuous_reset_level;
    } t_cfg;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic range;
        logic mul;
        logic pre;
        logic div_step;
        logic fin;
    } t_dp_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANGE,
        ST_MUL,
        ST_PRE,
        ST_DIV,
        ST_FIN
    } t_state;

endpackage

FILE: sv/hkrt_cfg_regs.sv
// Configuration register file for the rapid trigger unit.
module hkrt_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [hkrt_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [hkrt_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output hkrt_pkg::t_cfg                     o_cfg
);

    hkrt_pkg::t_cfg r_cfg;

    // Register writes, one per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.invert_orientation     <= 1'b0;
            r_cfg.total_travel           <= 10'd400;
            r_cfg.dead_zone              <= 10'd0;
            r_cfg.trigger_mode           <= hkrt_pkg::MODE_STATIC;
            r_cfg.actuation_point        <= 10'd200;
            r_cfg.press_threshold        <= 10'd20;
            r_cfg.release_threshold      <= 10'd20;
            r_cfg.continuous_reset_level <= 10'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hkrt_pkg::CFG_INVERT:      r_cfg.invert_orientation     <= i_cfg_data[0];
                hkrt_pkg::CFG_TRAVEL:      r_cfg.total_travel           <= i_cfg_data;
                hkrt_pkg::CFG_DEAD_ZONE:   r_cfg.dead_zone              <= i_cfg_data;
                hkrt_pkg::CFG_MODE:        r_cfg.trigger_mode           <= i_cfg_data[1:0];
                hkrt_pkg::CFG_ACTUATION:   r_cfg.actuation_point        <= i_cfg_data;
                hkrt_pkg::CFG_PRESS_THR:   r_cfg.press_threshold        <= i_cfg_data;
                hkrt_pkg::CFG_RELEASE_THR: r_cfg.release_threshold      <= i_cfg_data;
                hkrt_pkg::CFG_CONT_RESET:  r_cfg.continuous_reset_level <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/hkrt_ctrl.sv
// Sequencing state machine for the rapid trigger unit.
module hkrt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hkrt_pkg::t_dp_cmd o_cmd
);

    hkrt_pkg::t_state                     r_state, n_state;
    logic [hkrt_pkg::DIV_CNT_BITS-1:0]    r_count, n_count;
    logic                                 r_out_valid, n_out_valid;
    logic                                 slot_free;
    logic                                 div_last;

    assign slot_free = !r_out_valid || i_out_ready;
    assign div_last  = (r_count == hkrt_pkg::DIV_CNT_BITS'(hkrt_pkg::QUO_BITS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hkrt_pkg::ST_IDLE:  if (i_in_valid) n_state = hkrt_pkg::ST_RANGE;
            hkrt_pkg::ST_RANGE: n_state = hkrt_pkg::ST_MUL;
            hkrt_pkg::ST_MUL:   n_state = hkrt_pkg::ST_PRE;
            hkrt_pkg::ST_PRE:   n_state = hkrt_pkg::ST_DIV;
            hkrt_pkg::ST_DIV:   if (div_last) n_state = hkrt_pkg::ST_FIN;
            hkrt_pkg::ST_FIN:   if (slot_free) n_state = hkrt_pkg::ST_IDLE;
            default:            n_state = hkrt_pkg::ST_IDLE;
        endcase
    end

    // Datapath commands and handshake outputs
    always_comb begin
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        case (r_state)
            hkrt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            hkrt_pkg::ST_RANGE: o_cmd.range    = 1'b1;
            hkrt_pkg::ST_MUL:   o_cmd.mul      = 1'b1;
            hkrt_pkg::ST_PRE:   o_cmd.pre      = 1'b1;
            hkrt_pkg::ST_DIV:   o_cmd.div_step = 1'b1;
            hkrt_pkg::ST_FIN:   o_cmd.fin      = slot_free;
            default: begin
            end
        endcase
    end

    // Divider step count and output valid
    always_comb begin
        n_count = r_count;
        if (r_state == hkrt_pkg::ST_PRE) begin
            n_count = '0;
        end else if (r_state == hkrt_pkg::ST_DIV) begin
            n_count = r_count + 1'b1;
        end
        n_out_valid = r_out_valid;
        if (o_cmd.fin) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hkrt_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // A result is only written into a free output slot
    a_fin_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> (!r_out_valid || i_out_ready))
        else $error("result written over an untaken result");

    // Finishing an item always presents a result next cycle
    a_fin_then_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |=> r_out_valid)
        else $error("finished item produced no result");

    // Divider never runs past its step count
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hkrt_pkg::ST_DIV) |-> (r_count < hkrt_pkg::DIV_CNT_BITS'(hkrt_pkg::QUO_BITS)))
        else $error("divider step count overrun");

    // Every division is entered through the precheck cycle
    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == hkrt_pkg::ST_DIV) |-> $past(r_state == hkrt_pkg::ST_PRE))
        else $error("divider entered without setup");

endmodule

FILE: sv/hkrt_datapath.sv
// Per-key calibration state, distance divider and trigger decision datapath.
module hkrt_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hkrt_pkg::t_cfg     i_cfg,
    input  hkrt_pkg::t_dp_cmd  i_cmd,
    input  hkrt_pkg::t_in_item i_in_data,
    output hkrt_pkg::t_out_item o_out_data
);

    localparam int SB = hkrt_pkg::SAMPLE_BITS;
    localparam int DB = hkrt_pkg::DIST_BITS;
    localparam int QB = hkrt_pkg::QUO_BITS;
    localparam int NB = hkrt_pkg::NUM_BITS;
    localparam int EB = hkrt_pkg::LVL_EXT_BITS;
    localparam int GB = hkrt_pkg::SGN_BITS;

    // Per-key state
    logic [SB-1:0] r_rest [hkrt_pkg::NUM_KEYS];
    logic [SB-1:0] r_down [hkrt_pkg::NUM_KEYS];
    logic [DB-1:0] r_peak [hkrt_pkg::NUM_KEYS];
    logic [hkrt_pkg::NUM_KEYS-1:0] r_cal, r_zone, r_held;

    // Item registers
    logic [hkrt_pkg::KEY_BITS-1:0]     r_key;
    logic                              r_key_ok;
    logic [SB-1:0]                     r_smp;
    logic                              r_fr;
    logic [hkrt_pkg::KEY_IDX_BITS-1:0] idx;

    // Divider registers
    logic [NB-1:0] r_num;
    logic [SB-1:0] r_den;
    logic          r_neg;
    logic          r_zspan;
    logic          r_cal_q;
    logic          r_sat;
    logic [SB-1:0] r_rem;
    logic [QB-1:0] r_quo;

    hkrt_pkg::t_out_item r_out;

    assign idx = r_key[hkrt_pkg::KEY_IDX_BITS-1:0];

    // Range update terms: saturating dead-zone margins
    logic [EB-1:0] smp_ext, dz_ext, upper_ext, lower_ext;
    logic [SB-1:0] upper, lower;
    logic [SB-1:0] cur_rest, cur_down;
    logic          raise_down, lower_rest;

    always_comb begin
        smp_ext   = EB'(r_smp);
        dz_ext    = EB'(i_cfg.dead_zone);
        upper_ext = (smp_ext > dz_ext) ? (smp_ext - dz_ext) : '0;
        lower_ext = smp_ext + dz_ext;
        if (lower_ext > EB'(hkrt_pkg::FULL_SCALE)) begin
            lower_ext = EB'(hkrt_pkg::FULL_SCALE);
        end
        upper      = upper_ext[SB-1:0];
        lower      = lower_ext[SB-1:0];
        cur_rest   = r_rest[idx];
        cur_down   = r_down[idx];
        raise_down = cur_down < upper;
        lower_rest = !raise_down && (cur_rest > lower) &&
                     ((cur_down - upper) >= SB'(i_cfg.total_travel >> 1));
    end

    // Signed offsets for the distance mapping
    logic signed [SB:0] diff_s, span_s;
    logic [SB-1:0]      diff_mag, span_mag;

    always_comb begin
        diff_s   = $signed({1'b0, r_smp}) - $signed({1'b0, cur_rest});
        span_s   = $signed({1'b0, cur_down}) - $signed({1'b0, cur_rest});
        diff_mag = diff_s[SB] ? SB'(-diff_s) : diff_s[SB-1:0];
        span_mag = span_s[SB] ? SB'(-span_s) : span_s[SB-1:0];
    end

    // One restoring divider step
    logic [SB:0]   div_trial;
    logic          div_ge;
    logic [SB:0]   div_diff;

    always_comb begin
        div_trial = {r_rem, r_quo[QB-1]};
        div_ge    = div_trial >= {1'b0, r_den};
        div_diff  = div_trial - {1'b0, r_den};
    end

    // Final distance and trigger decision
    logic [DB-1:0] trav_dist;
    logic          pressed;
    logic          zone_n, held_n;
    logic [DB-1:0] peak_n;
    logic          trig_upd;
    logic signed [GB-1:0] d_s, ap_s, rt_s, pt_s, pk_s, crl_s;

    always_comb begin
        trav_dist = '0;
        if (!r_key_ok) begin
            trav_dist = '0;
        end else if (!r_cal_q) begin
            trav_dist = i_cfg.total_travel;
        end else if (r_zspan || r_neg) begin
            trav_dist = '0;
        end else if (r_sat || (r_quo > QB'(i_cfg.total_travel))) begin
            trav_dist = i_cfg.total_travel;
        end else begin
            trav_dist = r_quo[DB-1:0];
        end

        d_s   = $signed(GB'(trav_dist));
        ap_s  = $signed(GB'(i_cfg.actuation_point));
        rt_s  = $signed(GB'(i_cfg.release_threshold));
        pt_s  = $signed(GB'(i_cfg.press_threshold));
        pk_s  = $signed(GB'(r_peak[idx]));
        crl_s = $signed(GB'(i_cfg.continuous_reset_level));

        // Zone exit rule per mode
        zone_n = r_zone[idx];
        held_n = r_held[idx];
        if (i_cfg.trigger_mode == hkrt_pkg::MODE_RAPID) begin
            if (d_s <= ap_s - rt_s) zone_n = 1'b0;
        end else if (i_cfg.trigger_mode == hkrt_pkg::MODE_CONTINUOUS) begin
            if (d_s <= crl_s) zone_n = 1'b0;
        end

        // Press and release around the local maximum
        if ((d_s >= ap_s) && !zone_n) begin
            zone_n = 1'b1;
            held_n = 1'b1;
        end else if (!r_held[idx] && zone_n && (d_s >= pk_s + pt_s)) begin
            held_n = 1'b1;
        end else if (r_held[idx] && (!zone_n || (d_s <= pk_s - rt_s))) begin
            held_n = 1'b0;
        end

        peak_n = r_peak[idx];
        if ((held_n && (d_s > pk_s)) || (!held_n && (d_s < pk_s))) begin
            peak_n = trav_dist;
        end

        trig_upd = r_key_ok && r_cal_q && (i_cfg.trigger_mode != hkrt_pkg::MODE_STATIC);
        if (!r_key_ok || !r_cal_q) begin
            pressed = 1'b0;
        end else if (i_cfg.trigger_mode == hkrt_pkg::MODE_STATIC) begin
            pressed = trav_dist > i_cfg.actuation_point;
        end else begin
            pressed = held_n;
        end
    end

    // Per-key state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < hkrt_pkg::NUM_KEYS; k++) begin
                r_rest[k] <= hkrt_pkg::FULL_SCALE;
                r_down[k] <= '0;
                r_peak[k] <= '0;
            end
            r_cal  <= '0;
            r_zone <= '0;
            r_held <= '0;
        end else begin
            if (i_cmd.range && r_fr && r_key_ok) begin
                if (raise_down) begin
                    r_down[idx] <= upper;
                end else if (lower_rest) begin
                    r_rest[idx] <= lower;
                    r_cal[idx]  <= 1'b1;
                end
            end
            if (i_cmd.fin && trig_upd) begin
                r_zone[idx] <= zone_n;
                r_held[idx] <= held_n;
                r_peak[idx] <= peak_n;
            end
        end
    end

    // Item, multiplier, divider and output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key    <= i_in_data.key_index;
            r_key_ok <= 32'(i_in_data.key_index) < hkrt_pkg::NUM_KEYS;
            r_smp    <= i_cfg.invert_orientation ?
                        (hkrt_pkg::FULL_SCALE - i_in_data.sample) : i_in_data.sample;
            r_fr     <= i_in_data.filter_ready;
        end
        if (i_cmd.mul) begin
            r_num   <= NB'(diff_mag) * NB'(i_cfg.total_travel);
            r_den   <= span_mag;
            r_neg   <= diff_s[SB] ^ span_s[SB];
            r_zspan <= (span_mag == '0);
            r_cal_q <= r_cal[idx];
        end
        if (i_cmd.pre) begin
            r_sat <= (NB + 1)'(r_num) >= {r_den, {QB{1'b0}}};
            r_rem <= SB'(r_num[NB-1:QB]);
            r_quo <= r_num[QB-1:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_diff[SB-1:0] : div_trial[SB-1:0];
            r_quo <= {r_quo[QB-2:0], div_ge};
        end
        if (i_cmd.fin) begin
            r_out.key_out       <= r_key;
            r_out.pressed       <= pressed;
            r_out.is_calibrated <= r_key_ok && r_cal_q;
            r_out.distance      <= trav_dist;
        end
    end

    assign o_out_data = r_out;

    // Partial remainder stays below the divisor while dividing, unless the quotient saturates
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step && !r_sat) |-> (r_rem < r_den))
        else $error("divider remainder out of range");

endmodule

FILE: sv/hall_key_rapid_trigger_unit.sv
// Top level of the hall-effect key rapid trigger unit.
// Each transfer on the input channel brings one key's filtered sample; the unit updates that
// key's self-calibrating rest and down levels, maps the sample to a travel distance and applies
// the selected trigger mode, then returns one result on the output channel. An item passes
// through an acceptance cycle, a range update, a multiply, a divider setup, the restoring
// divider that produces the distance one bit per cycle, and a decision cycle that loads the
// output register. The decision cycle waits while an earlier result is still untaken.
// Items are handled one at a time; the result sits in an output register, so the next item is
// accepted while an earlier result waits to be taken.
// Configuration writes are accepted every cycle and must only be issued while the unit is idle.
module hall_key_rapid_trigger_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  hkrt_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output hkrt_pkg::t_out_item                o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hkrt_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [hkrt_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    hkrt_pkg::t_cfg    cfg;
    hkrt_pkg::t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    hkrt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Sequencer
    hkrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // Datapath
    hkrt_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule
